// ----- hw/rtl/prq_pkg.sv -----
// Package for the priority ready queue scheduler.
// Holds sizes, operation codes, memory word and request types, and index helpers.
// No dependencies.
package prq_pkg;

  localparam int unsigned PRIORITY_LEVELS = 32;
  localparam int unsigned MAX_THREADS     = 64;

  localparam int unsigned LEVEL_W = $clog2(PRIORITY_LEVELS);
  localparam int unsigned THR_W   = $clog2(MAX_THREADS);

  // Field widths fixed by the item format
  localparam int unsigned OP_W    = 3;
  localparam int unsigned TID_W   = 6;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned READY_W = 32;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_PICK    = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd2;
  localparam logic [OP_W-1:0] OP_SET     = 3'd3;
  localparam logic [OP_W-1:0] OP_TAKE    = 3'd4;

  // One word of the level memory: FIFO head and tail of one level
  typedef struct packed {
    logic [TID_W-1:0] head;
    logic [TID_W-1:0] tail;
  } lvl_entry_t;

  // Access requests from the control logic to the store
  typedef struct packed {
    logic                 lvl_re;
    logic [LEVEL_W-1:0]   lvl_raddr;
    logic                 lvl_we;
    logic [LEVEL_W-1:0]   lvl_waddr;
    lvl_entry_t           lvl_wdata;
    logic                 thr_re;
    logic [THR_W-1:0]     thr_raddr;
    logic                 link_we;
    logic [THR_W-1:0]     link_waddr;
    logic [TID_W-1:0]     link_wdata;
    logic                 prio_we;
    logic [THR_W-1:0]     prio_waddr;
    logic [PRIO_W-1:0]    prio_wdata;
  } store_req_t;

  // Map a thread id onto a thread memory index
  function automatic logic [THR_W-1:0] to_thr(input logic [TID_W-1:0] tid);
    logic [TID_W+THR_W-1:0] wide;
    wide = {{THR_W{1'b0}}, tid};
    return wide[THR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/prq_in_if.sv -----
// Request channel of the priority ready queue scheduler.
// Depends on prq_pkg for field widths.
interface prq_in_if;
  logic                         valid;
  logic                         ready;
  logic [prq_pkg::OP_W-1:0]     operation;
  logic [prq_pkg::TID_W-1:0]    thread_id;
  logic [prq_pkg::PRIO_W-1:0]   priority_req;

  modport source (output valid, operation, thread_id, priority_req, input ready);
  modport sink   (input valid, operation, thread_id, priority_req, output ready);
endinterface

// ----- hw/rtl/prq_out_if.sv -----
// Result channel of the priority ready queue scheduler.
// Depends on prq_pkg for field widths.
interface prq_out_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::TID_W-1:0]     picked_thread;
  logic                          idle;
  logic                          accepted;
  logic                          takers;
  logic                          resched;
  logic [prq_pkg::READY_W-1:0]   ready_levels;

  modport source (output valid, picked_thread, idle, accepted, takers, resched,
                  ready_levels, input ready);
  modport sink   (input valid, picked_thread, idle, accepted, takers, resched,
                  ready_levels, output ready);
endinterface

// ----- hw/rtl/prq_store.sv -----
// Queue storage: level head/tail memory, per-thread link and priority memories.
// Depends on prq_pkg. All reads are registered.
module prq_store (
  input  logic                         clk_i,
  input  prq_pkg::store_req_t          req_i,
  output prq_pkg::lvl_entry_t          lvl_rdata_o,
  output logic [prq_pkg::TID_W-1:0]    link_rdata_o,
  output logic [prq_pkg::PRIO_W-1:0]   prio_rdata_o
);
  import prq_pkg::*;

  lvl_entry_t         lvl_mem  [PRIORITY_LEVELS];
  logic [TID_W-1:0]   link_mem [MAX_THREADS];
  logic [PRIO_W-1:0]  prio_mem [MAX_THREADS];

  lvl_entry_t         lvl_rdata_q;
  logic [TID_W-1:0]   link_rdata_q;
  logic [PRIO_W-1:0]  prio_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.lvl_we) begin
      lvl_mem[req_i.lvl_waddr] <= req_i.lvl_wdata;
    end
    if (req_i.lvl_re) begin
      lvl_rdata_q <= lvl_mem[req_i.lvl_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    if (req_i.thr_re) begin
      link_rdata_q <= link_mem[req_i.thr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.prio_we) begin
      prio_mem[req_i.prio_waddr] <= req_i.prio_wdata;
    end
    if (req_i.thr_re) begin
      prio_rdata_q <= prio_mem[req_i.thr_raddr];
    end
  end

  assign lvl_rdata_o  = lvl_rdata_q;
  assign link_rdata_o = link_rdata_q;
  assign prio_rdata_o = prio_rdata_q;

endmodule

// ----- hw/rtl/priority_ready_queue_scheduler.sv -----
// Priority ready queue scheduler: per-level FIFOs of thread ids plus a ready bitmap.
// Enqueue, query, set, take and an idle pick load the result register from the execute
// state; a pick that finds a thread first reads the link/priority memory and loads the
// result from the pick state. One item at a time: a new item is taken only when idle,
// and a waiting result holds the next item. Reset clears the bitmap, queued bits, current
// thread, flag and default level; memories are not cleared.
module priority_ready_queue_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [prq_pkg::CFG_W-1:0]   cfg_wdata_i,
  prq_in_if.sink                      req_i,
  prq_out_if.source                   rsp_o
);
  import prq_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [OP_W-1:0]            op_q, op_d;
  logic [TID_W-1:0]           tid_q, tid_d;
  logic [PRIO_W-1:0]          prio_q, prio_d;
  logic [LEVEL_W-1:0]         lvl_q, lvl_d;

  logic [PRIORITY_LEVELS-1:0] ready_q, ready_d;
  logic [MAX_THREADS-1:0]     queued_q, queued_d;
  logic                       cur_valid_q, cur_valid_d;
  logic [PRIO_W-1:0]          cur_prio_q, cur_prio_d;
  logic                       resched_q, resched_d;
  logic [CFG_W-1:0]           dflt_q;

  // Output register
  logic                       out_valid_q, out_valid_d;
  logic [TID_W-1:0]           out_picked_q, out_picked_d;
  logic                       out_idle_q, out_idle_d;
  logic                       out_acc_q, out_acc_d;
  logic                       out_takers_q, out_takers_d;
  logic                       out_resched_q, out_resched_d;
  logic [READY_W-1:0]         out_levels_q, out_levels_d;

  store_req_t                 sreq;
  lvl_entry_t                 lvl_rdata;
  logic [TID_W-1:0]           link_rdata;
  logic [PRIO_W-1:0]          prio_rdata;

  logic                       accept;
  logic                       out_free;
  logic                       done;
  logic [LEVEL_W-1:0]         top_lvl;
  logic [LEVEL_W-1:0]         dflt_lvl;
  logic [LEVEL_W-1:0]         enq_lvl;
  logic [LEVEL_W-1:0]         query_lvl;
  logic                       takers_hit;
  logic                       tid_ok;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Highest non-empty level; the last set bit wins
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (ready_q[i]) top_lvl = LEVEL_W'(i);
    end
  end

  // Saturate the default level, then file out-of-range priorities there
  assign dflt_lvl = (32'(dflt_q) < PRIORITY_LEVELS) ? LEVEL_W'(dflt_q)
                                                     : LEVEL_W'(PRIORITY_LEVELS - 1);
  assign enq_lvl  = (32'(req_i.priority_req) < PRIORITY_LEVELS)
                    ? LEVEL_W'(req_i.priority_req) : dflt_lvl;

  // Query: clamp to the top level, then look for any ready level at or above it
  assign query_lvl = (32'(prio_q) < PRIORITY_LEVELS) ? LEVEL_W'(prio_q)
                                                      : LEVEL_W'(PRIORITY_LEVELS - 1);
  always_comb begin
    takers_hit = 1'b0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (32'(i) >= 32'(query_lvl)) takers_hit = takers_hit | ready_q[i];
    end
  end

  assign tid_ok = (32'(tid_q) < MAX_THREADS);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    tid_d         = tid_q;
    prio_d        = prio_q;
    lvl_d         = lvl_q;
    ready_d       = ready_q;
    queued_d      = queued_q;
    cur_valid_d   = cur_valid_q;
    cur_prio_d    = cur_prio_q;
    resched_d     = resched_q;
    sreq          = '0;
    done          = 1'b0;
    out_picked_d  = '0;
    out_idle_d    = 1'b0;
    out_acc_d     = 1'b0;
    out_takers_d  = 1'b0;
    out_resched_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Latch the item and start the level memory read
          op_d           = req_i.operation;
          tid_d          = req_i.thread_id;
          prio_d         = req_i.priority_req;
          lvl_d          = (req_i.operation == OP_PICK) ? top_lvl : enq_lvl;
          sreq.lvl_re    = 1'b1;
          sreq.lvl_raddr = lvl_d;
          state_d        = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (op_q == OP_PICK && ready_q != '0) begin
          // Fetch link and priority of the head thread
          sreq.thr_re    = 1'b1;
          sreq.thr_raddr = to_thr(lvl_rdata.head);
          state_d        = ST_PICK;
        end else if (out_free) begin
          done    = 1'b1;
          state_d = ST_IDLE;
          unique case (op_q)
            OP_ENQUEUE: begin
              if (tid_ok && !queued_q[to_thr(tid_q)]) begin
                out_acc_d           = 1'b1;
                sreq.lvl_we         = 1'b1;
                sreq.lvl_waddr      = lvl_q;
                sreq.lvl_wdata.head = ready_q[lvl_q] ? lvl_rdata.head : tid_q;
                sreq.lvl_wdata.tail = tid_q;
                // Append behind the old tail when the level is not empty
                sreq.link_we        = ready_q[lvl_q];
                sreq.link_waddr     = to_thr(lvl_rdata.tail);
                sreq.link_wdata     = tid_q;
                sreq.prio_we        = 1'b1;
                sreq.prio_waddr     = to_thr(tid_q);
                sreq.prio_wdata     = prio_q;
                ready_d[lvl_q]      = 1'b1;
                queued_d[to_thr(tid_q)] = 1'b1;
                if (cur_valid_q && prio_q > cur_prio_q) resched_d = 1'b1;
              end
              out_resched_d = resched_d;
            end
            OP_PICK: begin
              // Every level empty: report idle and drop the current thread
              out_idle_d    = 1'b1;
              cur_valid_d   = 1'b0;
              cur_prio_d    = '0;
              out_resched_d = resched_q;
            end
            OP_QUERY: begin
              out_takers_d  = takers_hit;
              out_resched_d = resched_q;
            end
            OP_SET: begin
              resched_d     = 1'b1;
              out_resched_d = 1'b1;
            end
            OP_TAKE: begin
              // Report the flag, then clear it
              out_resched_d = resched_q;
              resched_d     = 1'b0;
            end
            default: begin
              out_resched_d = resched_q;
            end
          endcase
        end
      end

      ST_PICK: begin
        if (out_free) begin
          done    = 1'b1;
          state_d = ST_IDLE;
          if (lvl_rdata.head == lvl_rdata.tail) begin
            ready_d[lvl_q] = 1'b0;
          end else begin
            // Advance the head along the link
            sreq.lvl_we         = 1'b1;
            sreq.lvl_waddr      = lvl_q;
            sreq.lvl_wdata.head = link_rdata;
            sreq.lvl_wdata.tail = lvl_rdata.tail;
          end
          queued_d[to_thr(lvl_rdata.head)] = 1'b0;
          cur_valid_d   = 1'b1;
          cur_prio_d    = prio_rdata;
          out_picked_d  = lvl_rdata.head;
          out_resched_d = resched_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_levels_d = READY_W'(ready_d);
  assign out_valid_d  = done ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  prq_store u_store (
    .clk_i        (clk_i),
    .req_i        (sreq),
    .lvl_rdata_o  (lvl_rdata),
    .link_rdata_o (link_rdata),
    .prio_rdata_o (prio_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= '0;
      queued_q    <= '0;
      cur_valid_q <= 1'b0;
      cur_prio_q  <= '0;
      resched_q   <= 1'b0;
      dflt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      queued_q    <= queued_d;
      cur_valid_q <= cur_valid_d;
      cur_prio_q  <= cur_prio_d;
      resched_q   <= resched_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
    end
  end

  // Item and result payload; no reset needed
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tid_q  <= tid_d;
    prio_q <= prio_d;
    lvl_q  <= lvl_d;
    if (done) begin
      out_picked_q  <= out_picked_d;
      out_idle_q    <= out_idle_d;
      out_acc_q     <= out_acc_d;
      out_takers_q  <= out_takers_d;
      out_resched_q <= out_resched_d;
      out_levels_q  <= out_levels_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.picked_thread = out_picked_q;
  assign rsp_o.idle          = out_idle_q;
  assign rsp_o.accepted      = out_acc_q;
  assign rsp_o.takers        = out_takers_q;
  assign rsp_o.resched       = out_resched_q;
  assign rsp_o.ready_levels  = out_levels_q;

  // There are at least as many queued threads as ready levels
  a_ready_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(queued_q) >= $countones(ready_q))
    else $error("ready level without a queued thread");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> out_free)
    else $error("result register overwritten");

  // Without a current thread the current priority stays zero
  a_cur_prio_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> (cur_prio_q == '0))
    else $error("stale current priority");

  // An idle pick only happens with an empty bitmap
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.idle) |-> (rsp_o.ready_levels == '0))
    else $error("idle reported with ready levels");

  // An accepted item always enters execution next
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

endmodule
